### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// each macro expects signals named clk and rst in the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define TPS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tps assertion failed: invariant");

// consequent holds at the same edge as the antecedent
`define TPS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tps assertion failed: implication");

// consequent holds at the clock edge after the antecedent
`define TPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tps assertion failed: next-cycle implication");

`endif

### hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Types and codes shared by the timed pattern sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  // operation codes on the item channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // special step kinds
  localparam logic [7:0] KIND_WAIT = 8'd2;
  localparam logic [7:0] KIND_LAST = 8'd3;

  // notice codes
  localparam logic [1:0] NOTICE_NONE  = 2'd0;
  localparam logic [1:0] NOTICE_TIMER = 2'd1;
  localparam logic [1:0] NOTICE_DONE  = 2'd2;

  // all outputs released (active low)
  localparam logic [7:0] RELEASED = 8'hFF;

  localparam int QUEUED_W = 5;

  // playback mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_RUN  = 3'b010,
    MODE_WAIT = 3'b100
  } mode_t;

  // one stored step record
  typedef struct packed {
    logic [7:0]  kind;
    logic [7:0]  mask;
    logic [15:0] delay;
  } step_t;

  // one result beat
  typedef struct packed {
    logic [7:0]          drive_out;
    logic                lamp_on;
    logic                playing;
    logic                awaiting_button;
    logic [QUEUED_W-1:0] queued;
    logic [1:0]          notice;
    logic                push_dropped;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/tps_step_mem.sv
// ----------------------------------------------------------------------------
// tps_step_mem
// Step record storage: one write port, one registered read port with
// write-through when both ports hit the same entry in a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_step_mem #(
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire tps_pkg::step_t    wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output tps_pkg::step_t         rd_data
);
  import tps_pkg::*;

  step_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, new data forwarded on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tps_player.sv
// ----------------------------------------------------------------------------
// tps_player
// Playback state, FIFO pointers and the single-pass next-state logic that
// turns one accepted beat into the new state and its result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tps_player #(
  parameter int FIFO_DEPTH = 16,
  parameter int PTR_W = $clog2(FIFO_DEPTH),
  parameter int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [1:0]       op,
  input  wire logic [15:0]      step_delay,
  input  wire logic [7:0]       step_mask,
  input  wire logic [7:0]       step_kind,
  input  wire logic             button_released,
  input  wire tps_pkg::step_t   head,
  output logic                  wr_en,
  output logic [PTR_W-1:0]      wr_addr,
  output tps_pkg::step_t        wr_data,
  output logic [PTR_W-1:0]      rd_addr,
  output tps_pkg::result_t      res
);
  import tps_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  step_t            current_step, current_step_next;
  logic [15:0]      tick_count, tick_count_next;
  mode_t            mode, mode_next;
  logic [7:0]       drive_reg, drive_reg_next;
  logic             lamp_reg, lamp_reg_next;

  logic [15:0] eff_delay;
  logic [15:0] half_delay;
  logic [15:0] tick_inc;
  logic        do_advance;
  logic [1:0]  notice;
  logic        dropped;

  // timing of the current step, zero delay counts as one
  assign eff_delay  = (current_step.delay == 16'd0) ? 16'd1 : current_step.delay;
  assign half_delay = eff_delay >> 1;
  assign tick_inc   = tick_count + 16'd1;

  // next state for one beat
  always_comb begin
    read_ptr_next     = read_ptr;
    write_ptr_next    = write_ptr;
    fill_count_next   = fill_count;
    current_step_next = current_step;
    tick_count_next   = tick_count;
    mode_next         = mode;
    drive_reg_next    = drive_reg;
    lamp_reg_next     = lamp_reg;
    do_advance        = 1'b0;
    notice            = NOTICE_NONE;
    dropped           = 1'b0;
    wr_en             = 1'b0;

    if (fire) begin
      unique case (op)
        OP_TICK: begin
          unique case (mode)
            MODE_WAIT: begin
              if (!button_released) begin
                lamp_reg_next   = 1'b1;
                drive_reg_next  = current_step.mask;
                mode_next       = MODE_RUN;
                tick_count_next = 16'd0;
                notice          = NOTICE_TIMER;
              end
            end
            MODE_RUN: begin
              tick_count_next = tick_inc;
              if (tick_inc >= eff_delay) begin
                do_advance = 1'b1;
              end else if ((half_delay != 16'd0) && (tick_inc == half_delay)) begin
                drive_reg_next = RELEASED;
              end
            end
            default: ;
          endcase
        end
        OP_PUSH: begin
          if (fill_count >= CNT_FULL) begin
            dropped = 1'b1;
          end else begin
            wr_en           = 1'b1;
            write_ptr_next  = (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
            fill_count_next = fill_count + 1'b1;
          end
        end
        OP_START: begin
          if (mode == MODE_IDLE) begin
            do_advance = 1'b1;
          end
        end
        OP_STOP: begin
          if (mode != MODE_IDLE) begin
            mode_next      = MODE_IDLE;
            drive_reg_next = RELEASED;
            lamp_reg_next  = 1'b1;
            notice         = NOTICE_DONE;
          end
        end
        default: ;
      endcase

      // take the head record and execute it, or end on an empty fifo
      if (do_advance) begin
        if (fill_count == '0) begin
          mode_next      = MODE_IDLE;
          drive_reg_next = RELEASED;
          lamp_reg_next  = 1'b1;
          notice         = NOTICE_DONE;
        end else begin
          current_step_next = head;
          read_ptr_next     = (read_ptr == PTR_LAST) ? '0 : read_ptr + 1'b1;
          fill_count_next   = fill_count - 1'b1;
          tick_count_next   = 16'd0;
          if (head.kind == KIND_WAIT) begin
            drive_reg_next = RELEASED;
            lamp_reg_next  = 1'b0;
            mode_next      = MODE_WAIT;
          end else begin
            drive_reg_next = head.mask;
            if (head.kind == KIND_LAST) begin
              mode_next     = MODE_IDLE;
              lamp_reg_next = 1'b1;
              notice        = NOTICE_DONE;
            end else begin
              mode_next = MODE_RUN;
            end
          end
        end
      end
    end
  end

  // storage ports: read ahead at the next head so it is ready for the next beat
  assign wr_addr = write_ptr;
  assign wr_data = '{kind: step_kind, mask: step_mask, delay: step_delay};
  assign rd_addr = read_ptr_next;

  // result of this beat
  assign res = '{
    drive_out:       drive_reg_next,
    lamp_on:         lamp_reg_next,
    playing:         (mode_next != MODE_IDLE),
    awaiting_button: (mode_next == MODE_WAIT),
    queued:          QUEUED_W'(fill_count_next),
    notice:          notice,
    push_dropped:    dropped
  };

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr     <= '0;
      write_ptr    <= '0;
      fill_count   <= '0;
      current_step <= '0;
      tick_count   <= '0;
      mode         <= MODE_IDLE;
      drive_reg    <= RELEASED;
      lamp_reg     <= 1'b1;
    end else begin
      read_ptr     <= read_ptr_next;
      write_ptr    <= write_ptr_next;
      fill_count   <= fill_count_next;
      current_step <= current_step_next;
      tick_count   <= tick_count_next;
      mode         <= mode_next;
      drive_reg    <= drive_reg_next;
      lamp_reg     <= lamp_reg_next;
    end
  end

  // checks
  `TPS_ASSERT_ALWAYS(a_fill_bound, fill_count <= CNT_FULL)
  `TPS_ASSERT_IMPLIES(a_wait_released, mode == MODE_WAIT,
                      (lamp_reg == 1'b0) && (drive_reg == RELEASED))
  `TPS_ASSERT_IMPLIES(a_idle_lamp, mode == MODE_IDLE, lamp_reg == 1'b1)
  `TPS_ASSERT_NEXT(a_push_counts, fire && (op == OP_PUSH) && (fill_count < CNT_FULL),
                   fill_count == $past(fill_count) + 1'b1)

endmodule

`default_nettype wire

### hw/rtl/timed_pattern_sequencer.sv
// a result beat is registered and shows in the cycle after its item is accepted
// throughput: one item per cycle unless a valid result is stalled; the player
//   state and the step storage read port are updated once per accepted beat
// reset: synchronous, active high; fifo empty, playback idle, drive state 0xFF,
//   lamp on; result payload and step storage are undefined until written
// ----------------------------------------------------------------------------
// timed_pattern_sequencer
// Queues step records and plays them out on timer ticks, with a result
// register between the player logic and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_pattern_sequencer #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] step_delay,
  input  wire logic [7:0]  step_mask,
  input  wire logic [7:0]  step_kind,
  input  wire logic        button_released,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       drive_out,
  output logic             lamp_on,
  output logic             playing,
  output logic             awaiting_button,
  output logic [4:0]       queued,
  output logic [1:0]       notice,
  output logic             push_dropped
);
  import tps_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic             fire;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  step_t            wr_data;
  step_t            head;
  result_t          res_next;
  result_t          res_q;

  // accept while the result register is empty or being drained
  assign item_stall = result_valid & result_stall;
  assign fire       = item_valid & ~item_stall;

  tps_step_mem #(
    .DEPTH (FIFO_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (head)
  );

  tps_player #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_player (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .op              (op),
    .step_delay      (step_delay),
    .step_mask       (step_mask),
    .step_kind       (step_kind),
    .button_released (button_released),
    .head            (head),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr         (rd_addr),
    .res             (res_next)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign drive_out       = res_q.drive_out;
  assign lamp_on         = res_q.lamp_on;
  assign playing         = res_q.playing;
  assign awaiting_button = res_q.awaiting_button;
  assign queued          = res_q.queued;
  assign notice          = res_q.notice;
  assign push_dropped    = res_q.push_dropped;

endmodule

`default_nettype wire
